FILE: src/message_duplicate_filter_assert.svh
// Assertion macros for the message duplicate filter.
`ifndef MESSAGE_DUPLICATE_FILTER_ASSERT_SVH
`define MESSAGE_DUPLICATE_FILTER_ASSERT_SVH
`ifndef SYNTH
`define MDF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("message_duplicate_filter: assertion failed");
`define MDF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("message_duplicate_filter: assertion failed");
`else
`define MDF_ASSERT(lbl, clk, rst_n, prop)
`define MDF_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: src/mdf_pkg.sv
// Shared types and constants of the message duplicate filter.
`default_nettype none
package mdf_pkg;

    // Verdict codes.
    localparam logic [2:0] VERD_DELIVER  = 3'd0;
    localparam logic [2:0] VERD_SHORT    = 3'd1;
    localparam logic [2:0] VERD_SIZE     = 3'd2;
    localparam logic [2:0] VERD_OWN      = 3'd3;
    localparam logic [2:0] VERD_CHECKSUM = 3'd4;
    localparam logic [2:0] VERD_DUP      = 3'd5;
    localparam logic [2:0] VERD_CONTROL  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OWN_NODE      = 2'd0;
    localparam logic [1:0] CFG_HEADER_BYTES  = 2'd1;
    localparam logic [1:0] CFG_REPLAY_WINDOW = 2'd2;

    // Register reset values.
    localparam logic [31:0] RST_OWN_NODE      = 32'd3;
    localparam logic [15:0] RST_HEADER_BYTES  = 16'd24;
    localparam logic [62:0] RST_REPLAY_WINDOW = 63'd5000000000;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_JUDGE,
        ST_DONE
    } t_state;

    // Write beat into the sender table.
    typedef struct packed {
        logic        we;
        logic [31:0] sender;
        logic [63:0] stamp;
    } t_tbl_wr;

endpackage
`default_nettype wire

FILE: src/mdf_table.sv
// Sender table: sender ids and last timestamps in one synchronous memory.
`default_nettype none
module mdf_table #(
    parameter int MAX_NODES = 16,
    parameter int IW        = 4
) (
    input  wire               i_clk,
    input  mdf_pkg::t_tbl_wr  i_wr,
    input  wire  [IW-1:0]     i_wr_addr,
    input  wire               i_rd_en,
    input  wire  [IW-1:0]     i_rd_addr,
    output logic [31:0]       o_rd_sender,
    output logic [63:0]       o_rd_stamp
);

    logic [31:0] r_sender_mem [MAX_NODES];
    logic [63:0] r_stamp_mem  [MAX_NODES];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_sender_mem[i_wr_addr] <= i_wr.sender;
            r_stamp_mem[i_wr_addr]  <= i_wr.stamp;
        end
        if (i_rd_en) begin
            o_rd_sender <= r_sender_mem[i_rd_addr];
            o_rd_stamp  <= r_stamp_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/message_duplicate_filter.sv
// Message duplicate filter: one verdict beat for every header beat.
//
// The input channel carries one message header per beat (i_in_valid, o_in_stall);
// the output channel returns one verdict and a table-full flag per beat
// (o_out_valid, i_out_stall). Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while idle,
// which the block itself does not enforce. A header rejected by its size, node or
// checksum goes straight to its verdict. Otherwise the sender table is walked one
// entry per cycle through the single read port of the table memory: a new sender
// gets its verdict after a walk over all filled entries, a sender found in the
// table once the walk stops at its entry and its compare and update states have
// run. One header is in work at a time, and the next is accepted once the previous
// verdict is loaded into the output register.
// The output register holds a verdict while the receiver stalls; a new
// header may be accepted meanwhile, but its verdict waits for the register.
// Reset clears the table fill count, the valid flags and the configuration
// registers to their defaults; the table contents need no clearing.
`default_nettype none
module message_duplicate_filter #(
    parameter int MAX_NODES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Header beats
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [31:0] i_sender_node,
    input  wire  [63:0] i_sent_time,
    input  wire  [31:0] i_topic_id,
    input  wire         i_checksum_ok,
    input  wire  [16:0] i_real_size,
    input  wire  [15:0] i_expected_size,
    // Verdict beats
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_verdict,
    output logic        o_table_full,
    // Configuration writes
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [62:0] i_cfg_data
);

`include "message_duplicate_filter_assert.svh"

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    mdf_pkg::t_state r_state;
    mdf_pkg::t_state n_state;

    logic [31:0] r_own_node;
    logic [15:0] r_header_bytes;
    logic [62:0] r_window;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic [IW-1:0] r_slot;
    logic [31:0]   r_sender;
    logic [63:0]   r_time;
    logic          r_ctrl;
    logic [63:0]   r_stored;
    logic          r_ge;
    logic [63:0]   r_gap;
    logic [2:0]    r_verdict;
    logic          r_full;
    logic          r_out_valid;
    logic [2:0]    r_out_verdict;
    logic          r_out_full;

    logic             accept;
    logic             size_known;
    logic             early;
    logic [2:0]       early_verdict;
    logic             scan_issue;
    logic             scan_hit;
    logic             scan_miss;
    logic             table_is_full;
    logic             dup;
    logic             out_free;
    logic [2:0]       pass_verdict;
    mdf_pkg::t_tbl_wr tbl_wr;
    logic [IW-1:0]    wr_addr;
    logic             rd_en;
    logic [31:0]      rd_sender;
    logic [63:0]      rd_stamp;

    mdf_table #(
        .MAX_NODES (MAX_NODES),
        .IW        (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr        (tbl_wr),
        .i_wr_addr   (wr_addr),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_idx[IW-1:0]),
        .o_rd_sender (rd_sender),
        .o_rd_stamp  (rd_stamp)
    );

    // Early checks on the incoming header, in priority order.
    always_comb begin
        size_known    = !i_real_size[16];
        early         = 1'b1;
        early_verdict = mdf_pkg::VERD_DELIVER;
        if (size_known && (i_real_size[15:0] < r_header_bytes)) begin
            early_verdict = mdf_pkg::VERD_SHORT;
        end else if (size_known && (i_real_size[15:0] != i_expected_size)) begin
            early_verdict = mdf_pkg::VERD_SIZE;
        end else if (i_sender_node == r_own_node) begin
            early_verdict = mdf_pkg::VERD_OWN;
        end else if (!i_checksum_ok) begin
            early_verdict = mdf_pkg::VERD_CHECKSUM;
        end else begin
            early = 1'b0;
        end
    end

    // Table walk status and the duplicate decision.
    assign accept        = i_in_valid && !o_in_stall;
    assign scan_hit      = r_pend && (rd_sender == r_sender);
    assign scan_issue    = (r_state == mdf_pkg::ST_SCAN) && (r_idx < r_count) && !scan_hit;
    assign scan_miss     = !r_pend && (r_idx == r_count);
    assign table_is_full = (r_count == CW'(MAX_NODES));
    assign dup           = r_ge && !(r_gap > {1'b0, r_window});
    assign out_free      = !r_out_valid || !i_out_stall;
    assign pass_verdict  = r_ctrl ? mdf_pkg::VERD_CONTROL : mdf_pkg::VERD_DELIVER;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mdf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = early ? mdf_pkg::ST_DONE : mdf_pkg::ST_SCAN;
                end
            end
            mdf_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_state = mdf_pkg::ST_CALC;
                end else if (scan_miss) begin
                    n_state = mdf_pkg::ST_DONE;
                end
            end
            mdf_pkg::ST_CALC:  n_state = mdf_pkg::ST_JUDGE;
            mdf_pkg::ST_JUDGE: n_state = mdf_pkg::ST_DONE;
            mdf_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = mdf_pkg::ST_IDLE;
                end
            end
            default: n_state = mdf_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: handshake, table read and table write.
    always_comb begin
        o_in_stall    = (r_state != mdf_pkg::ST_IDLE);
        rd_en         = scan_issue;
        tbl_wr.we     = 1'b0;
        tbl_wr.sender = r_sender;
        tbl_wr.stamp  = r_time;
        wr_addr       = r_slot;
        case (r_state)
            mdf_pkg::ST_SCAN: begin
                if (!scan_hit && scan_miss && !table_is_full) begin
                    tbl_wr.we = 1'b1;
                    wr_addr   = r_count[IW-1:0];
                end
            end
            mdf_pkg::ST_JUDGE: begin
                tbl_wr.we = !dup;
            end
            default: begin
                tbl_wr.we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mdf_pkg::ST_IDLE;
            r_count        <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_own_node     <= mdf_pkg::RST_OWN_NODE;
            r_header_bytes <= mdf_pkg::RST_HEADER_BYTES;
            r_window       <= mdf_pkg::RST_REPLAY_WINDOW;
        end else begin
            r_state <= n_state;
            // Configuration writes; an index beyond the list is ignored.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mdf_pkg::CFG_OWN_NODE:      r_own_node     <= i_cfg_data[31:0];
                    mdf_pkg::CFG_HEADER_BYTES:  r_header_bytes <= i_cfg_data[15:0];
                    mdf_pkg::CFG_REPLAY_WINDOW: r_window       <= i_cfg_data;
                    default: ;
                endcase
            end
            // A read issued this cycle is compared in the next one.
            if (r_state == mdf_pkg::ST_SCAN && !scan_hit && !scan_miss) begin
                r_pend <= scan_issue;
            end else begin
                r_pend <= 1'b0;
            end
            if (r_state == mdf_pkg::ST_SCAN && !scan_hit && scan_miss && !table_is_full) begin
                r_count <= r_count + 1'b1;
            end
            // Output register: load when free, drop when taken.
            if (r_state == mdf_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            mdf_pkg::ST_IDLE: begin
                if (accept) begin
                    r_sender  <= i_sender_node;
                    r_time    <= i_sent_time;
                    r_ctrl    <= i_topic_id[31] || (i_topic_id == 32'd0);
                    r_verdict <= early_verdict;
                    r_full    <= 1'b0;
                    r_idx     <= '0;
                end
            end
            mdf_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    r_slot   <= r_pend_idx;
                    r_stored <= rd_stamp;
                end else if (scan_miss) begin
                    // Unknown sender: stored as new, or flagged when no room.
                    r_verdict <= pass_verdict;
                    r_full    <= table_is_full;
                end else if (scan_issue) begin
                    r_pend_idx <= r_idx[IW-1:0];
                    r_idx      <= r_idx + 1'b1;
                end
            end
            mdf_pkg::ST_CALC: begin
                r_ge  <= $signed(r_stored) >= $signed(r_time);
                r_gap <= r_stored - r_time;
            end
            mdf_pkg::ST_JUDGE: begin
                r_verdict <= dup ? mdf_pkg::VERD_DUP : pass_verdict;
            end
            mdf_pkg::ST_DONE: begin
                if (out_free) begin
                    r_out_verdict <= r_verdict;
                    r_out_full    <= r_full;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_verdict    = r_out_verdict;
    assign o_table_full = r_out_full;

    // Checks on the table bookkeeping and the verdicts.
    `MDF_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_NODES))
    `MDF_ASSERT(a_write_slot, i_clk, i_rst_n, tbl_wr.we |-> (CW'(wr_addr) <= r_count))
    `MDF_ASSERT(a_full_not_rejected, i_clk, i_rst_n, (o_out_valid && o_table_full) |->
        (o_verdict == mdf_pkg::VERD_DELIVER || o_verdict == mdf_pkg::VERD_CONTROL))
    `MDF_ASSERT_NEXT(a_hit_to_calc, i_clk, i_rst_n,
        r_state == mdf_pkg::ST_SCAN && scan_hit, r_state == mdf_pkg::ST_CALC)

endmodule
`default_nettype wire
